@@ src/dsu_pkg.sv @@
// Shared types, constants and helpers for the disjoint-set union-find block.
// No dependencies; dsu_engine and disjoint_set_union_find import this package.
package dsu_pkg;

    localparam int MAX_NODES = 1024;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int CNT_W     = $clog2(MAX_NODES + 1);

    typedef enum logic [1:0] {
        ACT_UNION  = 2'd0,
        ACT_QUERY  = 2'd1,
        ACT_REINIT = 2'd2,
        ACT_NONE   = 2'd3
    } act_t;

    typedef struct packed {
        logic [1:0]        action;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
    } dsu_req_t;

    typedef struct packed {
        logic              connected;
        logic [NODE_W-1:0] root_a;
        logic [NODE_W-1:0] root_b;
        logic [CNT_W-1:0]  component_count;
        logic              bad_index;
    } dsu_rsp_t;

    typedef enum logic {
        EOP_FIND  = 1'b0,
        EOP_CLEAR = 1'b1
    } eng_op_t;

    typedef struct packed {
        logic              start;
        eng_op_t           op;
        logic              link;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
        logic [CNT_W-1:0]  limit;
    } eng_cmd_t;

    typedef struct packed {
        logic              idle;
        logic              done;
        logic              connected;
        logic              linked;
        logic [NODE_W-1:0] root_a;
        logic [NODE_W-1:0] root_b;
    } eng_stat_t;

    typedef enum logic [2:0] {
        E_CLEAR,
        E_IDLE,
        E_WALK_RD,
        E_WALK_CK,
        E_COMP_RD,
        E_COMP_WR,
        E_LINK
    } eng_state_t;

    typedef enum logic [1:0] {
        T_IDLE,
        T_RUN,
        T_OUT
    } top_state_t;

    // A node count of zero acts as one; counts above the table size are clamped.
    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = CNT_W'(1);
        end
        else if (v > CNT_W'(MAX_NODES))
        begin
            r = CNT_W'(MAX_NODES);
        end
        return r;
    endfunction

endpackage

@@ src/disjoint_set_union_find.sv @@
// Top level of the disjoint-set union-find block: request channel, result
// register, node count register and set counter. Depends on dsu_pkg, dsu_engine.
//
// Channel  Signals                      Direction  Moves
// request  in_valid/in_ready/in_data    in         action, node_a, node_b
// result   out_valid/out_ready/out_data out        roots, connected, count, error
// config   cfg_we/cfg_wdata             in         node_count, no wait
//
// Union or query runs both root searches and the compression passes through
// the single read port of the parent table. A bad index or undefined action
// skips the engine and goes straight to the output stage.
// Reinitialize sweeps the parent table entries below node_count, one entry per cycle.
// After reset and after each node_count write the same sweep runs and no
// request is accepted. A stalled result holds the block in its output stage.
module disjoint_set_union_find
    import dsu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  dsu_req_t         in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output dsu_rsp_t         out_data,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata
);

    top_state_t        tstate_reg, tstate_next;
    logic [CNT_W-1:0]  node_count_reg, node_count_next;
    logic [CNT_W-1:0]  set_count_reg, set_count_next;
    logic              out_valid_reg, out_valid_next;
    act_t              act_reg, act_next;
    logic              conn_reg, conn_next;
    logic              bad_reg, bad_next;
    logic [NODE_W-1:0] ra_reg, ra_next;
    logic [NODE_W-1:0] rb_reg, rb_next;
    dsu_rsp_t          out_reg, out_next;

    eng_cmd_t          cmd;
    eng_stat_t         stat;
    logic [CNT_W-1:0]  eff_n;
    logic              accept;
    logic              is_find;
    logic              bad_in;

    dsu_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat)
    );

    assign eff_n    = eff_count(node_count_reg);
    assign in_ready = (tstate_reg == T_IDLE) && stat.idle && !cfg_we;
    assign accept   = in_valid && in_ready;
    assign is_find  = in_data.action inside {ACT_UNION, ACT_QUERY};
    assign bad_in   = ({1'b0, in_data.node_a} >= eff_n) || ({1'b0, in_data.node_b} >= eff_n);

    always_comb
    begin
        cmd        = '0;
        cmd.node_a = in_data.node_a;
        cmd.node_b = in_data.node_b;
        cmd.link   = (in_data.action == ACT_UNION);
        cmd.limit  = eff_n;
        if (cfg_we)
        begin
            cmd.start = 1'b1;
            cmd.op    = EOP_CLEAR;
            cmd.limit = eff_count(cfg_wdata);
        end
        else if (accept && in_data.action == ACT_REINIT)
        begin
            cmd.start = 1'b1;
            cmd.op    = EOP_CLEAR;
        end
        else if (accept && is_find && !bad_in)
        begin
            cmd.start = 1'b1;
            cmd.op    = EOP_FIND;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tstate_reg     <= T_IDLE;
            node_count_reg <= CNT_W'(MAX_NODES);
            set_count_reg  <= CNT_W'(MAX_NODES);
            out_valid_reg  <= 1'b0;
            act_reg        <= ACT_NONE;
        end
        else
        begin
            tstate_reg     <= tstate_next;
            node_count_reg <= node_count_next;
            set_count_reg  <= set_count_next;
            out_valid_reg  <= out_valid_next;
            act_reg        <= act_next;
        end
    end

    always_ff @(posedge clk)
    begin
        conn_reg <= conn_next;
        bad_reg  <= bad_next;
        ra_reg   <= ra_next;
        rb_reg   <= rb_next;
        out_reg  <= out_next;
    end

    always_comb
    begin
        tstate_next     = tstate_reg;
        node_count_next = node_count_reg;
        set_count_next  = set_count_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        act_next        = act_reg;
        conn_next       = conn_reg;
        bad_next        = bad_reg;
        ra_next         = ra_reg;
        rb_next         = rb_reg;
        out_next        = out_reg;

        case (tstate_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    act_next  = act_t'(in_data.action);
                    conn_next = 1'b0;
                    ra_next   = '0;
                    rb_next   = '0;
                    bad_next  = is_find && bad_in;
                    if (in_data.action == ACT_REINIT)
                    begin
                        set_count_next = eff_n;
                        tstate_next    = T_RUN;
                    end
                    else if (is_find && !bad_in)
                    begin
                        tstate_next = T_RUN;
                    end
                    else
                    begin
                        tstate_next = T_OUT;
                    end
                end
            end
            T_RUN:
            begin
                if (stat.done)
                begin
                    if (act_reg != ACT_REINIT)
                    begin
                        conn_next = stat.connected;
                        ra_next   = stat.root_a;
                        rb_next   = stat.root_b;
                        if (stat.linked && set_count_reg != '0)
                        begin
                            set_count_next = set_count_reg - CNT_W'(1);
                        end
                    end
                    tstate_next = T_OUT;
                end
            end
            T_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next.connected       = conn_reg;
                    out_next.root_a          = ra_reg;
                    out_next.root_b          = rb_reg;
                    out_next.component_count = set_count_reg;
                    out_next.bad_index       = bad_reg;
                    out_valid_next           = 1'b1;
                    tstate_next              = T_IDLE;
                end
            end
            default:
            begin
                tstate_next = T_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            node_count_next = cfg_wdata;
            set_count_next  = eff_count(cfg_wdata);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

@@ src/dsu_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module dsu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ src/dsu_engine.sv @@
// Root-search sequencer: walks parent chains, compresses paths, links roots
// and sweeps the parent table. Depends on dsu_pkg and dsu_ram.
module dsu_engine
    import dsu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  eng_cmd_t  cmd,
    output eng_stat_t stat
);

    eng_state_t        state_reg, state_next;
    logic [NODE_W-1:0] cur_reg, cur_next;
    logic [NODE_W-1:0] x_reg, x_next;
    logic [NODE_W-1:0] root_reg, root_next;
    logic [NODE_W-1:0] ra_reg, ra_next;
    logic [NODE_W-1:0] b_reg, b_next;
    logic              second_reg, second_next;
    logic              link_reg, link_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  limit_reg, limit_next;

    logic              ram_we, ram_re;
    logic [NODE_W-1:0] ram_waddr, ram_wdata, ram_raddr, ram_rdata;
    logic [NODE_W-1:0] cmp_l, cmp_r;
    logic              eq;
    logic              done;

    dsu_ram #(
        .WIDTH (NODE_W),
        .DEPTH (MAX_NODES)
    ) u_parent (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The equality comparator shared by the walk check, compression and link steps.
    always_comb
    begin
        case (state_reg)
            E_WALK_CK:
            begin
                cmp_l = ram_rdata;
                cmp_r = cur_reg;
            end
            E_COMP_RD:
            begin
                cmp_l = cur_reg;
                cmp_r = root_reg;
            end
            default:
            begin
                cmp_l = ra_reg;
                cmp_r = root_reg;
            end
        endcase
    end

    assign eq = (cmp_l == cmp_r);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= E_CLEAR;
            idx_reg    <= '0;
            limit_reg  <= CNT_W'(MAX_NODES);
            second_reg <= 1'b0;
            link_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            limit_reg  <= limit_next;
            second_reg <= second_next;
            link_reg   <= link_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        x_reg    <= x_next;
        root_reg <= root_next;
        ra_reg   <= ra_next;
        b_reg    <= b_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        cur_next    = cur_reg;
        x_next      = x_reg;
        root_next   = root_reg;
        ra_next     = ra_reg;
        b_next      = b_reg;
        second_next = second_reg;
        link_next   = link_reg;
        idx_next    = idx_reg;
        limit_next  = limit_reg;
        ram_we      = 1'b0;
        ram_waddr   = cur_reg;
        ram_wdata   = root_reg;
        ram_re      = 1'b0;
        ram_raddr   = cur_reg;
        done        = 1'b0;

        case (state_reg)
            E_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg[NODE_W-1:0];
                ram_wdata = idx_reg[NODE_W-1:0];
                if (idx_reg == limit_reg - CNT_W'(1))
                begin
                    done       = 1'b1;
                    state_next = E_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            E_IDLE:
            begin
                if (cmd.start && cmd.op == EOP_FIND)
                begin
                    cur_next    = cmd.node_a;
                    x_next      = cmd.node_a;
                    b_next      = cmd.node_b;
                    link_next   = cmd.link;
                    second_next = 1'b0;
                    state_next  = E_WALK_RD;
                end
            end
            E_WALK_RD:
            begin
                ram_re     = 1'b1;
                state_next = E_WALK_CK;
            end
            E_WALK_CK:
            begin
                if (eq)
                begin
                    root_next  = cur_reg;
                    cur_next   = x_reg;
                    state_next = E_COMP_RD;
                end
                else
                begin
                    cur_next   = ram_rdata;
                    state_next = E_WALK_RD;
                end
            end
            E_COMP_RD:
            begin
                if (eq)
                begin
                    if (!second_reg)
                    begin
                        ra_next     = root_reg;
                        second_next = 1'b1;
                        x_next      = b_reg;
                        cur_next    = b_reg;
                        state_next  = E_WALK_RD;
                    end
                    else
                    begin
                        state_next = E_LINK;
                    end
                end
                else
                begin
                    ram_re     = 1'b1;
                    state_next = E_COMP_WR;
                end
            end
            E_COMP_WR:
            begin
                ram_we     = 1'b1;
                cur_next   = ram_rdata;
                state_next = E_COMP_RD;
            end
            E_LINK:
            begin
                ram_waddr  = root_reg;
                ram_wdata  = ra_reg;
                ram_we     = link_reg && !eq;
                done       = 1'b1;
                state_next = E_IDLE;
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase

        if (cmd.start && cmd.op == EOP_CLEAR)
        begin
            state_next = E_CLEAR;
            idx_next   = '0;
            limit_next = cmd.limit;
        end
    end

    assign stat.idle      = (state_reg == E_IDLE);
    assign stat.done      = done;
    assign stat.connected = (state_reg == E_LINK) && eq;
    assign stat.linked    = (state_reg == E_LINK) && link_reg && !eq;
    assign stat.root_a    = ra_reg;
    assign stat.root_b    = root_reg;

    // Every table write lands inside the nodes in use.
    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ({1'b0, ram_waddr} < limit_reg))
        else $error("parent table write beyond node count");

    // A root search is only started from the idle state.
    a_find_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.start && cmd.op == EOP_FIND) |-> (state_reg == E_IDLE))
        else $error("root search started while busy");

    // A chain that has not reached its root is read again at the next node.
    a_walk_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == E_WALK_CK && ram_rdata != cur_reg)
        |=> (state_reg == E_WALK_RD || state_reg == E_CLEAR))
        else $error("walk stopped before reaching a root");

endmodule
